// File: rtl/sha256_pkg.sv
// shared types and constants for the sha-256 stream hasher
// used by sha256_ctrl, sha256_dp and sha256_stream_hasher; no dependencies
package sha256_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned NUM_WV  = 8;
    localparam int unsigned NUM_RND = 64;

    localparam logic [5:0] BLOCK_LAST = 6'd63;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [1:0] WORD_LAST  = 2'd3;
    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

    localparam logic [WORD_W-1:0] IV [NUM_WV] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WORD_W-1:0] RK [NUM_RND] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // source of the byte shifted into the block window
    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_PAD,
        SEL_ZERO,
        SEL_LEN
    } t_byte_sel;

    // commands from the controller to the datapath
    typedef struct packed {
        logic      push;
        t_byte_sel byte_sel;
        logic      count_bits;
        logic      load;
        logic      round;
        logic      fold;
        logic      restart;
        logic [5:0] round_idx;
        logic [2:0] len_idx;
        logic [1:0] word_idx;
    } t_dp_cmd;

endpackage

// File: rtl/sha256_stream_hasher.sv
// top level of the sha-256 stream hasher
// instantiates sha256_ctrl and sha256_dp; depends on sha256_pkg
//
//  channel  dir  tdata                 tuser            tlast
//  s_*      in   [7:0] data_byte       [0] byte_valid   end_of_message
//  m_*      out  [63:0] digest_word    [1:0] word_index last_word
//
// a request carrying a byte is taken while the block is idle; the request that fills
// a block also runs a compression (load, 64 rounds on one shared round unit, fold)
// a final request pads one byte per cycle, pausing while a block compresses, and runs
// one or two more blocks, then offers the digest as four requests on the m side
// s_tready is low from a final request until the fourth digest word is taken
// and while a block compresses; stalls on m hold the digest word
// synchronous active-low reset restores the initial hash and clears counts
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tuser,   // [0] byte_valid
    input  logic        i_s_tlast,   // end_of_message
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [63:0] digest_word
    output logic [1:0]  o_m_tuser,   // [1:0] word_index
    output logic        o_m_tlast    // last_word
);
    import sha256_pkg::*;

    t_dp_cmd cmd;

    // controller: byte count, padding sequence, round count, output handshake
    sha256_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .i_m_tready (i_m_tready),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .o_cmd      (cmd)
    );

    // datapath: window, round unit, chain words, bit count
    sha256_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_s_tdata),
        .o_digest_word (o_m_tdata)
    );

    // never take a request while a digest is on offer
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("input accepted while digest pending");

    // a final request closes the input side
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> !o_s_tready)
        else $error("input open after final request");

    // digest words go out in order with no gap in valid
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) |=>
            (o_m_tvalid && (o_m_tuser == $past(o_m_tuser) + 2'd1)))
        else $error("digest word out of order");

    // after the last digest word the block is ready for a new message
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> (o_s_tready && !o_m_tvalid))
        else $error("no restart after digest");

endmodule

// File: rtl/sha256_ctrl.sv
// sequencer for the sha-256 stream hasher: byte count, padding, rounds, output
// depends on sha256_pkg; drives sha256_dp through a t_dp_cmd struct
module sha256_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic               i_s_tuser,
    input  logic               i_s_tlast,
    input  logic               i_m_tready,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    output logic [1:0]         o_m_tuser,
    output logic               o_m_tlast,
    output sha256_pkg::t_dp_cmd o_cmd
);
    import sha256_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD80,
        S_PADZ,
        S_LEN,
        S_LOAD,
        S_ROUND,
        S_FOLD,
        S_OUT
    } t_state;

    t_state     r_state;
    t_state     r_ret;
    logic [5:0] r_cnt;
    logic [5:0] r_round;
    logic [1:0] r_word;
    logic       s_acc;
    logic       m_acc;

    assign s_acc = i_s_tvalid && o_s_tready;
    assign m_acc = o_m_tvalid && i_m_tready;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = (r_state == S_OUT);
    assign o_m_tuser  = r_word;
    assign o_m_tlast  = (r_word == WORD_LAST);

    always_comb begin
        o_cmd           = '0;
        o_cmd.round_idx = r_round;
        o_cmd.len_idx   = r_cnt[2:0];
        o_cmd.word_idx  = r_word;
        case (r_state)
            S_IDLE: begin
                if (s_acc && i_s_tuser) begin
                    o_cmd.push       = 1'b1;
                    o_cmd.byte_sel   = SEL_DATA;
                    o_cmd.count_bits = 1'b1;
                end
            end
            S_PAD80: begin
                o_cmd.push     = 1'b1;
                o_cmd.byte_sel = SEL_PAD;
            end
            S_PADZ: begin
                if (r_cnt != LEN_POS) begin
                    o_cmd.push     = 1'b1;
                    o_cmd.byte_sel = SEL_ZERO;
                end
            end
            S_LEN: begin
                o_cmd.push     = 1'b1;
                o_cmd.byte_sel = SEL_LEN;
            end
            S_LOAD:  o_cmd.load  = 1'b1;
            S_ROUND: o_cmd.round = 1'b1;
            S_FOLD:  o_cmd.fold  = 1'b1;
            S_OUT: begin
                if (m_acc && (r_word == WORD_LAST)) begin
                    o_cmd.restart = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_cnt   <= '0;
            r_round <= '0;
            r_word  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        if (i_s_tuser) begin
                            r_cnt <= r_cnt + 6'd1;
                            if (r_cnt == BLOCK_LAST) begin
                                r_state <= S_LOAD;
                                r_ret   <= i_s_tlast ? S_PAD80 : S_IDLE;
                            end else if (i_s_tlast) begin
                                r_state <= S_PAD80;
                            end
                        end else if (i_s_tlast) begin
                            r_state <= S_PAD80;
                        end
                    end
                end
                S_PAD80: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == BLOCK_LAST) begin
                        r_state <= S_LOAD;
                        r_ret   <= S_PADZ;
                    end else begin
                        r_state <= S_PADZ;
                    end
                end
                S_PADZ: begin
                    if (r_cnt == LEN_POS) begin
                        r_state <= S_LEN;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                        if (r_cnt == BLOCK_LAST) begin
                            r_state <= S_LOAD;
                            r_ret   <= S_PADZ;
                        end
                    end
                end
                S_LEN: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == BLOCK_LAST) begin
                        r_state <= S_LOAD;
                        r_ret   <= S_OUT;
                    end
                end
                S_LOAD: begin
                    r_round <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_round <= r_round + 6'd1;
                    if (r_round == ROUND_LAST) begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    r_state <= r_ret;
                end
                S_OUT: begin
                    if (m_acc) begin
                        r_word <= r_word + 2'd1;
                        if (r_word == WORD_LAST) begin
                            r_state <= S_IDLE;
                            r_cnt   <= '0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/sha256_dp.sv
// datapath for the sha-256 stream hasher: block window and schedule, round
// unit, chain words and bit count; depends on sha256_pkg
module sha256_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha256_pkg::t_dp_cmd i_cmd,
    input  logic [7:0]          i_data_byte,
    output logic [63:0]         o_digest_word
);
    import sha256_pkg::*;

    function automatic logic [WORD_W-1:0] ror(input logic [WORD_W-1:0] v, input int n);
        return (v >> n) | (v << (WORD_W - n));
    endfunction

    logic [WORD_W-1:0] r_chain [NUM_WV];
    logic [WORD_W-1:0] r_wv    [NUM_WV];
    logic [511:0]      r_win;
    logic [63:0]       r_bits;

    logic [7:0]        byte_in;
    logic [WORD_W-1:0] w0, w1, w9, w14, new_w;
    logic [WORD_W-1:0] big_s1, big_s0, choose, major, tmp1, tmp2;

    // oldest schedule word sits in the top bits of the window
    assign w0  = r_win[511:480];
    assign w1  = r_win[479:448];
    assign w9  = r_win[223:192];
    assign w14 = r_win[63:32];

    assign new_w = w0 + (ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3)) + w9
                 + (ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10));

    assign big_s1 = ror(r_wv[4], 6) ^ ror(r_wv[4], 11) ^ ror(r_wv[4], 25);
    assign choose = (r_wv[4] & r_wv[5]) ^ (~r_wv[4] & r_wv[6]);
    assign tmp1   = r_wv[7] + big_s1 + choose + RK[i_cmd.round_idx] + w0;
    assign big_s0 = ror(r_wv[0], 2) ^ ror(r_wv[0], 13) ^ ror(r_wv[0], 22);
    assign major  = (r_wv[0] & r_wv[1]) ^ (r_wv[0] & r_wv[2]) ^ (r_wv[1] & r_wv[2]);
    assign tmp2   = big_s0 + major;

    always_comb begin
        case (i_cmd.byte_sel)
            SEL_DATA: byte_in = i_data_byte;
            SEL_PAD:  byte_in = PAD_BYTE;
            SEL_ZERO: byte_in = '0;
            SEL_LEN:  byte_in = r_bits[{~i_cmd.len_idx, 3'b000} +: 8];
            default:  byte_in = '0;
        endcase
    end

    assign o_digest_word = {r_chain[{i_cmd.word_idx, 1'b0}], r_chain[{i_cmd.word_idx, 1'b1}]};

    // chain words and bit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= IV;
            r_bits  <= '0;
        end else if (i_cmd.restart) begin
            r_chain <= IV;
            r_bits  <= '0;
        end else begin
            if (i_cmd.fold) begin
                for (int i = 0; i < NUM_WV; i++) begin
                    r_chain[i] <= r_chain[i] + r_wv[i];
                end
            end
            if (i_cmd.count_bits) begin
                r_bits <= r_bits + BITS_PER_BYTE;
            end
        end
    end

    // window and working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_win <= {r_win[503:0], byte_in};
        end else if (i_cmd.round) begin
            r_win <= {r_win[479:0], new_w};
        end
        if (i_cmd.load) begin
            r_wv <= r_chain;
        end else if (i_cmd.round) begin
            r_wv[0] <= tmp1 + tmp2;
            r_wv[1] <= r_wv[0];
            r_wv[2] <= r_wv[1];
            r_wv[3] <= r_wv[2];
            r_wv[4] <= r_wv[3] + tmp1;
            r_wv[5] <= r_wv[4];
            r_wv[6] <= r_wv[5];
            r_wv[7] <= r_wv[6];
        end
    end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// self-checking bench for sha256_stream_hasher: message bytes in, 256-bit digest out
// depends on the rtl top level only; the digest is predicted by a sha-256 model kept here
module tb_top;

    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no request taken on either side
    localparam int LONG_HOLD      = 300;   // one long receiver hold-off
    localparam int DRAIN_CYCLES   = 200;   // settle time after the last digest word
    localparam int RANDOM_ITEMS   = 250;   // least number of requests queued in the random phase

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] HASH_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // one request on the s side
    typedef struct {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } t_msg_item;

    // one digest word on the m side
    typedef struct {
        logic [63:0] word;
        logic [1:0]  idx;
        logic        last;
    } t_digest_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
    logic        s_tuser = 1'b0;    // [0] byte_valid
    logic        s_tlast = 1'b0;    // end_of_message
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;           // [63:0] digest_word
    logic [1:0]  m_tuser;           // [1:0] word_index
    logic        m_tlast;           // last_word

    t_msg_item    byte_q [$];       // requests waiting for the driver
    t_digest_word digest_q [$];     // predicted digest words, oldest first

    // predictor state
    logic [31:0] hv [8];
    logic [7:0]  msg_block [64];
    logic [5:0]  block_fill;
    logic [63:0] bit_total;

    int        err_count = 0;
    int        stim_phase = 0;      // 0 directed, 1 random
    bit        tx_busy = 1'b0;      // driver holds a request not yet taken
    t_msg_item cur_item;
    int        tx_gap = 0;
    int        tx_burst = 0;
    int        rx_stall = 0;
    int        rx_burst = 0;
    int        hold_left = 0;
    bit        hold_done = 1'b0;
    int        idle_cycles = 0;

    sha256_stream_hasher dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // one sha-256 compression of msg_block into the chain words
    function automatic void run_compression();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, s0, s1, t1, t2;
        int t;
        for (t = 0; t < 16; t++) begin
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        end
        for (t = 16; t < 64; t++) begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3];
        e = hv[4]; f = hv[5]; g = hv[6]; h = hv[7];
        for (t = 0; t < 64; t++) begin
            s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
            t1 = h + s1 + ((e & f) ^ (~e & g)) + ROUND_K[t] + w[t];
            s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
            t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d;
        hv[4] += e; hv[5] += f; hv[6] += g; hv[7] += h;
    endfunction

    function automatic void hash_restart();
        int i;
        for (i = 0; i < 8; i++) hv[i] = HASH_INIT[i];
        block_fill = '0;
        bit_total = '0;
    endfunction

    // absorb one accepted request; a message end queues the four digest words
    function automatic void hash_absorb(input t_msg_item it);
        t_digest_word dw;
        int pos;
        int k;
        if (it.valid) begin
            msg_block[block_fill] = it.data;
            bit_total += 64'd8;
            block_fill += 6'd1;
            if (block_fill == 6'd0) run_compression();
        end
        if (!it.last) return;
        pos = block_fill;
        msg_block[pos] = PAD_MARK;
        pos++;
        // no room left for the length: pad out and spill into a second block
        if (pos > 56) begin
            while (pos < 64) begin
                msg_block[pos] = 8'h00;
                pos++;
            end
            run_compression();
            pos = 0;
        end
        while (pos < 56) begin
            msg_block[pos] = 8'h00;
            pos++;
        end
        for (k = 0; k < 8; k++) msg_block[56 + k] = bit_total[63 - 8*k -: 8];
        run_compression();
        for (k = 0; k < 4; k++) begin
            dw.word = {hv[2*k], hv[2*k+1]};
            dw.idx = k[1:0];
            dw.last = (k == 3);
            digest_q.insert(digest_q.size(), dw);
        end
        hash_restart();
    endfunction

    // idle length: mostly none or short, a few long, now and then a burst with none
    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void queue_item(input logic [7:0] data, input logic valid,
                                       input logic last);
        t_msg_item it;
        it.data = data;
        it.valid = valid;
        it.last = last;
        byte_q.insert(byte_q.size(), it);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch: %s got %h expected %h", $realtime, what, got, want);
        err_count++;
    endtask

    // wait until the driver is empty and every predicted digest word has come
    task automatic wait_drained();
        while (byte_q.size() != 0 || tx_busy || digest_q.size() != 0) @(posedge i_clk);
    endtask

    // driver: takes requests from byte_q, idles a random gap after each
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            tx_busy = 1'b0;
            hash_restart();
        end else begin
            // a request taken at this edge goes through the predictor right away
            if (s_tvalid && s_tready) begin
                hash_absorb(cur_item);
                tx_busy = 1'b0;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (byte_q.size() > 0) begin
                    cur_item = byte_q.pop_front();
                    tx_busy = 1'b1;
                    s_tdata <= cur_item.data;
                    s_tuser <= cur_item.valid;
                    s_tlast <= cur_item.last;
                    s_tvalid <= 1'b1;
                    tx_gap = pick_gap(tx_burst);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver ready: random stalls, plus one long hold-off on the first digest
    // of the random phase so the block backs up and holds s_tready low
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && stim_phase == 1 && m_tvalid) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) rx_stall = pick_gap(rx_burst);
            if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // monitor: each digest word against the oldest prediction
    always @(posedge i_clk) begin
        t_digest_word want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (digest_q.size() == 0) begin
                report_mismatch("digest word with none predicted", m_tdata, 64'h0);
            end else begin
                want = digest_q.pop_front();
                if (m_tdata !== want.word)
                    report_mismatch("digest_word", m_tdata, want.word);
                if (m_tuser !== want.idx)
                    report_mismatch("word_index", {62'h0, m_tuser}, {62'h0, want.idx});
                if (m_tlast !== want.last)
                    report_mismatch("last_word", {63'h0, m_tlast}, {63'h0, want.last});
            end
        end
    end

    // watchdog: too long with nothing taken on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int len;
        int n_items;
        int n_msgs;
        int i;
        bit end_empty;

        // directed messages
        queue_item(8'hA5, 1'b0, 1'b1);          // empty message
        queue_item(8'h00, 1'b1, 1'b1);          // single zero byte, end on the byte
        queue_item(8'hFF, 1'b1, 1'b0);          // single ff byte ...
        queue_item(8'h5A, 1'b0, 1'b0);          // ... an ignored request in between ...
        queue_item(8'h3C, 1'b0, 1'b1);          // ... and an end without a byte
        queue_item(8'hC3, 1'b0, 1'b0);          // ignored request between messages
        queue_item(8'h61, 1'b1, 1'b0);          // "abc"
        queue_item(8'h62, 1'b1, 1'b0);
        queue_item(8'h63, 1'b1, 1'b1);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender pauses here until the directed digests are all back
        wait_drained();
        stim_phase = 1;

        // random messages, lengths mostly short, some on the padding boundaries
        n_items = 0;
        n_msgs = 0;
        while (n_items < RANDOM_ITEMS || n_msgs < 6) begin
            if ($urandom_range(0, 99) < 18) begin
                case ($urandom_range(0, 8))
                    0: len = 55;
                    1: len = 56;
                    2: len = 57;
                    3: len = 63;
                    4: len = 64;
                    5: len = 65;
                    6: len = 119;
                    7: len = 120;
                    default: len = 128;
                endcase
            end else begin
                len = $urandom_range(0, 24);
            end
            end_empty = (len == 0) || ($urandom_range(0, 3) == 0);
            for (i = 0; i < len; i++) begin
                if ($urandom_range(0, 99) < 8) begin
                    queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                    n_items++;
                end
                queue_item(8'($urandom_range(0, 255)), 1'b1, !end_empty && i == len - 1);
                n_items++;
            end
            if (end_empty) begin
                queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                n_items++;
            end
            n_msgs++;
            // now and then an ignored request between messages
            if ($urandom_range(0, 4) == 0) begin
                queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                n_items++;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && digest_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/sha256_pkg.sv
rtl/sha256_ctrl.sv
rtl/sha256_dp.sv
rtl/sha256_stream_hasher.sv
test/tb_top.sv
